### rtl/rgbe_scanline_encoder_defines.svh
// assertion macros for the rgbe scanline encoder
// no dependencies; included by the top level only
`ifndef RGBE_SCANLINE_ENCODER_DEFINES_SVH
`define RGBE_SCANLINE_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RGBE_ASSERT_IMPLY(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
`define RGBE_ASSERT_NEVER(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error(msg);
`else
`define RGBE_ASSERT_IMPLY(label, ck, rs, ante, cons, msg)
`define RGBE_ASSERT_NEVER(label, ck, rs, cond, msg)
`endif
`endif

### rtl/rgbe_pkg.sv
// shared types and constants for the rgbe scanline encoder
// no dependencies
package rgbe_pkg;

  localparam logic        KIND_PIXEL       = 1'b0;
  localparam logic        KIND_TICK        = 1'b1;
  localparam logic [30:0] TINY_BITS        = 31'h0A4FB11E;
  localparam logic [7:0]  HDR_MAGIC        = 8'd2;
  localparam logic [7:0]  EXP_OFFSET       = 8'd2;
  localparam logic [2:0]  HDR_STEP_HI      = 3'd2;
  localparam logic [2:0]  HDR_STEP_LO      = 3'd3;
  localparam logic [2:0]  HDR_DATA         = 3'd4;
  localparam logic [1:0]  PLANE_LAST       = 2'd3;
  localparam logic [12:0] LINE_WIDTH_RESET = 13'd1024;
  localparam logic        REG_LINE_WIDTH   = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
  } q_item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } q_status_t;

endpackage

### rtl/rgbe_scanline_encoder.sv
// rgbe scanline encoder top level: apb register, front end, queue, back end
// depends on rgbe_pkg, rgbe_front, rgbe_queue, rgbe_back and the defines header
//
// input stream (s_*): one item per handshake; tuser is the kind (pixel or tick),
// tdata carries red, green, blue as ieee single bit patterns. pixels become rgbe
// words in a ping-pong line store; each tick emits one byte of the oldest full
// line (2, 2, width high, width low, then per plane counted literal chunks).
// output stream (m_*): tdata is the byte, tlast marks the last byte of a line,
// tuser flags a pixel dropped because both banks were full (tdata then 0).
// accepted pixels and ticks with no full line give no output.
// throughput: one item per cycle in and one byte per cycle out while the
// receiver is ready, set by the back end state update and its one store port
// per side. an accepted item is registered in the front end stage, then in a
// queue slot; its result is held in the back end output register.
// a stalled receiver fills the output register and then the queue, after
// which s_tready drops; no item is lost. reset clears all control state and
// empties both banks; the store itself is not cleared. line_width (offset 0)
// must be written over apb only while idle; the block does not enforce this.
`include "rgbe_scanline_encoder_defines.svh"
module rgbe_scanline_encoder import rgbe_pkg::*; #(
  parameter int MAX_WIDTH   = 4096,
  parameter int CHUNK_MAX   = 127,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // red [31:0], green [63:32], blue [95:64]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // byte_out
  output logic        m_tlast,   // line_end
  output logic        m_tuser,   // dropped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] line_width;
  q_status_t   q_stat;
  q_item_t     q_item;
  q_item_t     q_head;
  logic        q_push;
  logic        q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LINE_WIDTH)) begin
      line_width <= pwdata[12:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {19'd0, line_width} : 32'd0;

  rgbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  rgbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  rgbe_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHUNK_MAX (CHUNK_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .q_valid    (!q_stat.empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  `RGBE_ASSERT_NEVER(a_no_push_full, clk, rst, q_stat.full && q_push, "queue overflow")
  `RGBE_ASSERT_NEVER(a_no_pop_empty, clk, rst, q_stat.empty && q_pop, "queue underflow")
  `RGBE_ASSERT_IMPLY(a_drop_clean, clk, rst, m_tvalid && m_tuser, (m_tdata == 8'd0) && !m_tlast, "dropped result carries data")

endmodule

### rtl/rgbe_queue.sv
// short fifo between the pixel front end and the line store back end
// depends on rgbe_pkg
module rgbe_queue import rgbe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   head,
  output q_status_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  q_item_t          slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  assign head             = slots[rd_ptr];
  assign stat.empty       = (count == '0);
  assign stat.full        = (count == CNTW'(DEPTH));
  assign stat.almost_full = (count >= CNTW'(DEPTH - 1));

endmodule

### rtl/rgbe_front.sv
// front end: accepts pixels and ticks, converts pixels to rgbe words
// depends on rgbe_pkg; feeds rgbe_queue
module rgbe_front import rgbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // red [31:0], green [63:32], blue [95:64]
  input  logic        s_tuser,   // kind
  input  q_status_t   q_stat,
  output logic        q_push,
  output q_item_t     q_item
);

  typedef struct packed {
    logic       neg;
    logic [7:0] ex;
    logic [7:0] mhi;
  } chan_t;

  typedef struct packed {
    logic       kind;
    chan_t      r;
    chan_t      g;
    chan_t      b;
    logic [7:0] dexp;
    logic       zero;
  } stage_t;

  function automatic chan_t split(input logic [31:0] bits);
    chan_t c;
    c.neg = bits[31];
    c.ex  = (bits[30:23] == 8'd0) ? 8'd1 : bits[30:23];
    c.mhi = {(bits[30:23] != 8'd0), bits[22:16]};
    return c;
  endfunction

  function automatic logic [7:0] chan_byte(input chan_t c, input logic [7:0] dexp);
    logic [8:0] diff;
    diff = {1'b0, dexp} - {1'b0, c.ex};
    if (c.neg || (diff[8:4] != 5'd0)) begin
      return 8'd0;
    end
    return c.mhi >> diff[3:0];
  endfunction

  logic [31:0] r_bits;
  logic [31:0] g_bits;
  logic [31:0] b_bits;
  logic [30:0] dmax;
  logic        nonfin;
  logic        accept;
  logic        stg_valid;
  stage_t      stg;

  assign r_bits = s_tdata[31:0];
  assign g_bits = s_tdata[63:32];
  assign b_bits = s_tdata[95:64];

  always_comb begin
    dmax = '0;
    if (!r_bits[31] && (r_bits[30:0] > dmax)) begin
      dmax = r_bits[30:0];
    end
    if (!g_bits[31] && (g_bits[30:0] > dmax)) begin
      dmax = g_bits[30:0];
    end
    if (!b_bits[31] && (b_bits[30:0] > dmax)) begin
      dmax = b_bits[30:0];
    end
  end

  assign nonfin = (r_bits[30:23] == 8'hFF) || (g_bits[30:23] == 8'hFF) ||
                  (b_bits[30:23] == 8'hFF);

  assign s_tready = stg_valid ? !q_stat.almost_full : !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= accept;
    end
    if (accept) begin
      stg.kind <= s_tuser;
      stg.r    <= split(r_bits);
      stg.g    <= split(g_bits);
      stg.b    <= split(b_bits);
      stg.dexp <= dmax[30:23];
      stg.zero <= nonfin || (dmax <= TINY_BITS);
    end
  end

  assign q_push      = stg_valid;
  assign q_item.kind = stg.kind;
  assign q_item.word = (stg.zero || (stg.kind == KIND_TICK)) ? 32'd0 :
                       {stg.dexp + EXP_OFFSET, chan_byte(stg.b, stg.dexp),
                        chan_byte(stg.g, stg.dexp), chan_byte(stg.r, stg.dexp)};

endmodule

### rtl/rgbe_back.sv
// back end: ping-pong line store, line header and literal chunk drain
// depends on rgbe_pkg; fed by rgbe_queue
module rgbe_back import rgbe_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int CHUNK_MAX = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] line_width,
  input  logic        q_valid,
  input  q_item_t     q_head,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // byte_out
  output logic        m_tlast,   // line_end
  output logic        m_tuser    // dropped
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int COLW = $clog2(MAX_WIDTH + 1);

  logic [31:0] line_mem [2 ** (AW + 1)];

  logic [COLW-1:0] w_use;
  logic [15:0]     lw16;
  logic [15:0]     w16;
  logic [COLW-1:0] write_column, write_column_next;
  logic            write_bank, write_bank_next;
  logic [1:0]      bank_full, bank_full_next;
  logic            drain_bank, drain_bank_next;
  logic [2:0]      header_step, header_step_next;
  logic [1:0]      drain_plane, drain_plane_next;
  logic [COLW-1:0] drain_column, drain_column_next;
  logic [6:0]      chunk_left, chunk_left_next;

  logic            advance;
  logic            exec;
  logic            mem_we;
  logic            mem_re;
  logic            do_finish;
  logic            res_valid;
  logic            res_data;
  logic [7:0]      res_byte;
  logic            res_last;
  logic            res_drop;
  logic [COLW-1:0] col_inc;
  logic [COLW-1:0] drain_inc;
  logic [COLW-1:0] left;
  logic [15:0]     cnt16;

  logic            pend_valid;
  logic            pend_data;
  logic [1:0]      pend_plane;
  logic [7:0]      pend_byte;
  logic            pend_last;
  logic            pend_drop;
  logic [31:0]     rd_word;

  assign lw16  = 16'(line_width);
  assign w16   = (lw16 == 16'd0) ? 16'd1 :
                 ((lw16 > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : lw16);
  assign w_use = COLW'(w16);

  assign advance = !pend_valid || m_tready;
  assign exec    = q_valid && advance;
  assign q_pop   = exec;

  assign col_inc   = write_column + COLW'(1);
  assign drain_inc = drain_column + COLW'(1);
  assign left      = (drain_column < w_use) ? (w_use - drain_column) : '0;
  assign cnt16     = (16'(left) < 16'(CHUNK_MAX)) ? 16'(left) : 16'(CHUNK_MAX);

  always_comb begin
    write_column_next = write_column;
    write_bank_next   = write_bank;
    bank_full_next    = bank_full;
    drain_bank_next   = drain_bank;
    header_step_next  = header_step;
    drain_plane_next  = drain_plane;
    drain_column_next = drain_column;
    chunk_left_next   = chunk_left;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    do_finish = 1'b0;
    res_valid = 1'b0;
    res_data  = 1'b0;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    res_drop  = 1'b0;
    if (exec) begin
      if (q_head.kind == KIND_PIXEL) begin
        if (bank_full[write_bank]) begin
          res_valid = 1'b1;
          res_drop  = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (col_inc >= w_use) begin
            bank_full_next[write_bank] = 1'b1;
            write_bank_next   = ~write_bank;
            write_column_next = '0;
          end else begin
            write_column_next = col_inc;
          end
        end
      end else if (bank_full[drain_bank]) begin
        res_valid = 1'b1;
        if (header_step != HDR_DATA) begin
          priority if (header_step < HDR_STEP_HI) begin
            res_byte = HDR_MAGIC;
          end else if (header_step == HDR_STEP_HI) begin
            res_byte = w16[15:8];
          end else begin
            res_byte = w16[7:0];
          end
          header_step_next = header_step + 3'd1;
          if (header_step == HDR_STEP_LO) begin
            drain_plane_next  = '0;
            drain_column_next = '0;
            chunk_left_next   = '0;
          end
        end else if (chunk_left == 7'd0) begin
          res_byte        = cnt16[7:0];
          chunk_left_next = cnt16[6:0];
          do_finish       = (cnt16 == 16'd0);
        end else begin
          mem_re            = 1'b1;
          res_data          = 1'b1;
          drain_column_next = drain_inc;
          chunk_left_next   = chunk_left - 7'd1;
          do_finish         = (drain_inc >= w_use);
        end
      end
    end
    if (do_finish) begin
      drain_column_next = '0;
      chunk_left_next   = '0;
      if (drain_plane == PLANE_LAST) begin
        drain_plane_next = '0;
        header_step_next = '0;
        bank_full_next[drain_bank] = 1'b0;
        drain_bank_next  = ~drain_bank;
        res_last         = 1'b1;
      end else begin
        drain_plane_next = drain_plane + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[{write_bank, write_column[AW-1:0]}] <= q_head.word;
    end
    if (mem_re) begin
      rd_word <= line_mem[{drain_bank, drain_column[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_column <= '0;
      write_bank   <= 1'b0;
      bank_full    <= '0;
      drain_bank   <= 1'b0;
      header_step  <= '0;
      drain_plane  <= '0;
      drain_column <= '0;
      chunk_left   <= '0;
      pend_valid   <= 1'b0;
    end else begin
      write_column <= write_column_next;
      write_bank   <= write_bank_next;
      bank_full    <= bank_full_next;
      drain_bank   <= drain_bank_next;
      header_step  <= header_step_next;
      drain_plane  <= drain_plane_next;
      drain_column <= drain_column_next;
      chunk_left   <= chunk_left_next;
      if (advance) begin
        pend_valid <= exec && res_valid;
      end
    end
    if (exec) begin
      pend_data  <= res_data;
      pend_plane <= drain_plane;
      pend_byte  <= res_byte;
      pend_last  <= res_last;
      pend_drop  <= res_drop;
    end
  end

  assign m_tvalid = pend_valid;
  assign m_tdata  = pend_data ? rd_word[8 * pend_plane +: 8] : pend_byte;
  assign m_tlast  = pend_last;
  assign m_tuser  = pend_drop;

endmodule

### tb/rgbe_scanline_encoder_tb.sv
// testbench for rgbe_scanline_encoder: pixel and tick requests against an rgbe line predictor
// depends on rgbe_pkg and the rgbe_scanline_encoder rtl; self-checking, stands alone
module rgbe_scanline_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbe_pkg::*;

  localparam int unsigned MAX_W = 4096;
  localparam int unsigned CHUNK = 127;
  localparam logic REG_UNUSED = 1'b1;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       dropped;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // red [31:0], green [63:32], blue [95:64]
  logic        s_tuser = KIND_PIXEL;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // byte_out
  logic        m_tlast;  // line_end
  logic        m_tuser;  // dropped
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgbe_scanline_encoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  logic [31:0] enc_store [2*MAX_W];
  bit          filled [2*MAX_W];
  logic [12:0] width_reg = LINE_WIDTH_RESET;
  int unsigned fill_col = 0;
  bit          fill_bank = 0;
  logic [1:0]  bank_ready = '0;
  bit          out_bank = 0;
  logic [2:0]  hdr_step = '0;
  logic [1:0]  out_plane = '0;
  int unsigned out_col = 0;
  int unsigned chunk_rem = 0;

  enc_byte_t   exp_bytes [$];
  enc_byte_t   head;
  int unsigned mismatches = 0;
  bit          src_gaps = 1;
  bit          sink_stalls = 1;

  function automatic int unsigned span_of(logic [12:0] val);
    if (val == 0) return 1;
    if (val > MAX_W) return MAX_W;
    return 32'(val);
  endfunction

  function automatic logic [7:0] chan_byte(logic [31:0] bits, logic [7:0] dexp);
    logic [7:0]  ex;
    logic [23:0] mant;
    int          sh;
    if (bits[31]) return 8'd0;
    ex = bits[30:23];
    mant = {1'b0, bits[22:0]};
    if (ex != 0) mant[23] = 1'b1;
    else ex = 8'd1;
    sh = int'(dexp) - int'(ex) + 16;
    if (sh < 0 || sh >= 32) return 8'd0;
    return 8'(mant >> sh);
  endfunction

  function automatic logic [31:0] rgbe_of(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    logic [31:0] ch [3];
    logic [31:0] d;
    logic        found;
    logic [7:0]  dexp;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    d = '0;
    found = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (ch[k][30:23] == 8'hFF) return 32'd0;
      if (!ch[k][31] && (!found || ch[k] > d)) begin
        d = ch[k];
        found = 1'b1;
      end
    end
    if (!found || d <= {1'b0, TINY_BITS}) return 32'd0;
    dexp = d[30:23];
    return {8'(dexp + EXP_OFFSET), chan_byte(b, dexp), chan_byte(g, dexp), chan_byte(r, dexp)};
  endfunction

  function automatic logic close_plane();
    out_col = 0;
    chunk_rem = 0;
    if (out_plane == PLANE_LAST) begin
      out_plane = '0;
      hdr_step = '0;
      bank_ready[out_bank] = 1'b0;
      out_bank = !out_bank;
      return 1'b1;
    end
    out_plane = out_plane + 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_item(logic kind, logic [31:0] r, logic [31:0] g,
                                       logic [31:0] b);
    int unsigned w;
    int unsigned left;
    int unsigned slot;
    enc_byte_t   e;
    w = span_of(width_reg);
    e = '{8'd0, 1'b0, 1'b0};
    if (kind == KIND_PIXEL) begin
      if (bank_ready[fill_bank]) begin
        e.dropped = 1'b1;
        exp_bytes.push_back(e);
        return;
      end
      slot = fill_bank * MAX_W + fill_col % MAX_W;
      enc_store[slot] = rgbe_of(r, g, b);
      filled[slot] = 1;
      fill_col++;
      if (fill_col >= w) begin
        bank_ready[fill_bank] = 1'b1;
        fill_bank = !fill_bank;
        fill_col = 0;
      end
      return;
    end
    if (!bank_ready[out_bank]) return;
    if (hdr_step < HDR_DATA) begin
      if (hdr_step < HDR_STEP_HI) e.data = HDR_MAGIC;
      else if (hdr_step == HDR_STEP_HI) e.data = 8'(w >> 8);
      else e.data = 8'(w);
      hdr_step = hdr_step + 1'b1;
      if (hdr_step == HDR_DATA) begin
        out_plane = '0;
        out_col = 0;
        chunk_rem = 0;
      end
    end else if (chunk_rem == 0) begin
      left = out_col < w ? w - out_col : 0;
      chunk_rem = left < CHUNK ? left : CHUNK;
      e.data = 8'(chunk_rem);
      if (left == 0) e.last = close_plane();
    end else begin
      e.data = 8'(enc_store[out_bank * MAX_W + out_col % MAX_W] >> (8 * out_plane));
      out_col++;
      chunk_rem--;
      if (out_col >= w) e.last = close_plane();
    end
    exp_bytes.push_back(e);
  endfunction

  // no full bank may expose store entries that were never written
  function automatic bit width_safe(int unsigned nw);
    for (int bk = 0; bk < 2; bk++) begin
      if (bank_ready[bk]) begin
        for (int unsigned c = 0; c < nw; c++) begin
          if (!filled[bk * MAX_W + c]) return 0;
        end
      end
    end
    return 1;
  endfunction

  task automatic send_item(logic kind, logic [31:0] r, logic [31:0] g, logic [31:0] b);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {b, g, r};
    do @(posedge clk); while (!s_tready);
    predict_item(kind, r, g, b);
  endtask

  function automatic logic [31:0] rand_channel(logic [7:0] top);
    logic [31:0]  v;
    int unsigned  pick;
    int unsigned  off;
    v = $urandom;
    pick = $urandom_range(0, 19);
    off = $urandom_range(0, 9);
    if (pick < 12) begin
      v[30:23] = top > off ? 8'(top - off) : 8'd0;
      v[31] = ($urandom_range(0, 3) == 0);
    end else if (pick < 14) begin
      v[30:0] = '0;
    end else if (pick == 14) begin
      v[30:23] = 8'hFF;
    end else if (pick == 15) begin
      v[30:23] = 8'h00;
    end
    return v;
  endfunction

  task automatic send_pixel();
    logic [7:0] top;
    top = 8'($urandom_range(1, 254));
    if ($urandom_range(0, 7) == 0) top = 8'($urandom_range(18, 22));
    send_item(KIND_PIXEL, rand_channel(top), rand_channel(top), rand_channel(top));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic drain_lines();
    while (bank_ready != 0) send_tick();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (exp_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_LINE_WIDTH) width_reg = data[12:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_line_width(logic [12:0] val);
    logic [31:0] wd;
    wait_idle();
    if (!width_safe(span_of(val))) begin
      drain_lines();
      wait_idle();
    end
    wd = {($urandom_range(0, 1) != 0) ? 19'($urandom) : 19'd0, val};
    apb_write({REG_LINE_WIDTH, 2'b00}, wd);
  endtask

  // output side: random stall before each byte request
  initial begin
    int unsigned stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (exp_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, got %02h last %0b dropped %0b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        head = exp_bytes.pop_front();
        if (m_tdata !== head.data) begin
          mismatches++;
          $display("%0t: byte expected %02h got %02h", $time, head.data, m_tdata);
        end
        if (m_tlast !== head.last) begin
          mismatches++;
          $display("%0t: line end expected %0b got %0b", $time, head.last, m_tlast);
        end
        if (m_tuser !== head.dropped) begin
          mismatches++;
          $display("%0t: dropped expected %0b got %0b", $time, head.dropped, m_tuser);
        end
      end
    end
  end

  task automatic test_idle_ticks();
    repeat (3) send_tick();
  endtask

  task automatic test_pixel_corners();
    set_line_width(13'd12);
    send_item(KIND_PIXEL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_PIXEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_PIXEL, 32'hBF80_0000, 32'hC000_0000, 32'h8000_0001);
    send_item(KIND_PIXEL, 32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_item(KIND_PIXEL, 32'h3F80_0000, 32'hFFFF_FFFF, 32'hFF80_0000);
    send_item(KIND_PIXEL, {1'b0, TINY_BITS}, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_PIXEL, {1'b0, TINY_BITS} + 32'd1, 32'h0000_0000, 32'h0A00_0000);
    send_item(KIND_PIXEL, 32'h7F7F_FFFF, 32'h7F00_0000, 32'h0000_0001);
    send_item(KIND_PIXEL, 32'h7E80_0000, 32'h7E7F_FFFF, 32'h7FC0_0000);
    send_item(KIND_PIXEL, 32'hBF80_0000, 32'h3F80_0000, 32'h3F00_0000);
    send_item(KIND_PIXEL, 32'h0B00_0000, 32'h0040_0000, 32'h0A80_0000);
    send_item(KIND_PIXEL, 32'h3F80_0000, 32'h3F40_0000, 32'h3E80_0000);
    drain_lines();
  endtask

  task automatic test_full_banks_drop();
    // zero saturates to a one-pixel line
    set_line_width(13'd0);
    repeat (4) send_pixel();
    drain_lines();
    set_line_width(13'd1);
    repeat (3) send_pixel();
    send_tick();
    send_pixel();
    drain_lines();
  endtask

  task automatic test_register_decode();
    set_line_width(13'd2);
    apb_write({REG_UNUSED, 2'b00}, 32'd9);
    repeat (2) send_pixel();
    drain_lines();
  endtask

  task automatic test_chunk_boundaries();
    // one full chunk then a one-byte chunk per plane
    set_line_width(13'd128);
    repeat (128) send_pixel();
    drain_lines();
  endtask

  task automatic test_width_change_mid_line();
    set_line_width(13'd6);
    repeat (6) send_pixel();
    repeat (8) send_tick();
    repeat (4) send_pixel();
    // drain is past the new width, so the next byte ends the plane
    set_line_width(13'd2);
    send_tick();
    send_pixel();
    drain_lines();
    repeat (3) send_pixel();
    set_line_width(13'd9);
    repeat (6) send_pixel();
    drain_lines();
  endtask

  task automatic test_random_stream();
    logic [12:0] w;
    int unsigned tick_bias;
    repeat (2) begin
      case ($urandom_range(0, 7))
        0: w = 13'd0;
        1: w = 13'd1;
        default: w = 13'($urandom_range(2, 40));
      endcase
      set_line_width(w);
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      tick_bias = $urandom_range(20, 85);
      repeat (25) begin
        if ($urandom_range(0, 99) < tick_bias) send_tick();
        else send_pixel();
      end
    end
    src_gaps = 1;
    sink_stalls = 1;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_pixel_corners();
    test_full_banks_drop();
    test_register_decode();
    test_chunk_boundaries();
    test_width_change_mid_line();
    test_random_stream();
    drain_lines();
    @(negedge clk);
    s_tvalid <= 1'b0;
    for (int n = 0; n < 5000 && exp_bytes.size() != 0; n++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (exp_bytes.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected bytes never arrived, next expected %02h", $time,
               exp_bytes.size(), exp_bytes[0].data);
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rgbe_pkg.sv
rtl/rgbe_queue.sv
rtl/rgbe_front.sv
rtl/rgbe_back.sv
rtl/rgbe_scanline_encoder.sv
tb/rgbe_scanline_encoder_tb.sv
